FILE: src/tgarle_pkg.sv
`timescale 1ns / 1ps

package tgarle_pkg;

	// Header geometry
	localparam int unsigned HDR_LEN = 18;
	localparam int unsigned HDR_POS_W = 5;
	localparam logic [HDR_POS_W-1:0] HDR_LAST = HDR_POS_W'(HDR_LEN - 1);

	// One input beat as it leaves the input register
	typedef struct packed {
		logic [7:0] file_byte;
		logic       start_of_file;
	} tgarle_beat_t;

	// One decoded result
	typedef struct packed {
		logic [31:0] pixel_word;
		logic [7:0]  repeat_count;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        last_of_image;
		logic        packet_clamped;
	} tgarle_result_t;

endpackage

FILE: src/tgarle_in_stage.sv
`timescale 1ns / 1ps

module tgarle_in_stage
	import tgarle_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [7:0]   file_byte,
	input  logic         start_of_file,
	input  logic         down_ready,
	output logic         beat_valid,
	output tgarle_beat_t beat
);

	logic         valid_s1;
	tgarle_beat_t beat_s1;
	logic         take;
	logic         advance;

	assign advance  = valid_s1 && down_ready;
	assign in_stall = valid_s1 && !down_ready;
	assign take     = in_valid && !in_stall;

	// Hold a beat until the decoder consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			beat_s1.file_byte     <= file_byte;
			beat_s1.start_of_file <= start_of_file;
		end
	end

	assign beat_valid = valid_s1;
	assign beat       = beat_s1;

endmodule

FILE: src/tgarle_parser.sv
`timescale 1ns / 1ps

module tgarle_parser
	import tgarle_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step_en,
	input  tgarle_beat_t   beat,
	output logic           res_valid,
	output tgarle_result_t res
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_ID     = 3'd1;
	localparam logic [2:0] PH_PKT    = 3'd2;
	localparam logic [2:0] PH_PIX    = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	localparam logic [HDR_POS_W-1:0] POS_ID_LEN = HDR_POS_W'(0);
	localparam logic [HDR_POS_W-1:0] POS_W_LO   = HDR_POS_W'(12);
	localparam logic [HDR_POS_W-1:0] POS_W_HI   = HDR_POS_W'(13);
	localparam logic [HDR_POS_W-1:0] POS_H_LO   = HDR_POS_W'(14);
	localparam logic [HDR_POS_W-1:0] POS_H_HI   = HDR_POS_W'(15);

	localparam logic [1:0] LAST_BYTE = 2'd3;

	// Registered decoder state
	logic [2:0]           phase_q;
	logic [HDR_POS_W-1:0] hdr_pos_q;
	logic [7:0]           id_left_q;
	logic [15:0]          width_q;
	logic [15:0]          height_q;
	logic [31:0]          pix_left_q;
	logic                 is_run_q;
	logic [7:0]           pkt_left_q;
	logic [1:0]           byte_idx_q;
	logic [23:0]          asm_q;

	// State as seen by this beat (restart folded in)
	logic [2:0]           phase_e;
	logic [HDR_POS_W-1:0] hdr_pos_e;
	logic [7:0]           id_left_e;
	logic [15:0]          width_e;
	logic [15:0]          height_e;
	logic [31:0]          pix_left_e;
	logic                 is_run_e;
	logic [7:0]           pkt_left_e;
	logic [1:0]           byte_idx_e;
	logic [23:0]          asm_e;

	// Next state
	logic [2:0]           phase_d;
	logic [HDR_POS_W-1:0] hdr_pos_d;
	logic [7:0]           id_left_d;
	logic [15:0]          width_d;
	logic [15:0]          height_d;
	logic [31:0]          pix_left_d;
	logic                 is_run_d;
	logic [7:0]           pkt_left_d;
	logic [1:0]           byte_idx_d;
	logic [23:0]          asm_d;

	logic [7:0]  b;
	logic        sof;
	logic [7:0]  rep;
	logic        clamp;
	logic        last;
	logic        emit;
	logic [31:0] area;

	assign b   = beat.file_byte;
	assign sof = beat.start_of_file;

	// Drop the current file on a start mark
	always_comb begin
		if (sof) begin
			phase_e    = PH_HEADER;
			hdr_pos_e  = '0;
			id_left_e  = '0;
			width_e    = '0;
			height_e   = '0;
			pix_left_e = '0;
			is_run_e   = 1'b0;
			pkt_left_e = '0;
			byte_idx_e = '0;
			asm_e      = '0;
		end else begin
			phase_e    = phase_q;
			hdr_pos_e  = hdr_pos_q;
			id_left_e  = id_left_q;
			width_e    = width_q;
			height_e   = height_q;
			pix_left_e = pix_left_q;
			is_run_e   = is_run_q;
			pkt_left_e = pkt_left_q;
			byte_idx_e = byte_idx_q;
			asm_e      = asm_q;
		end
	end

	assign area = 32'(width_e) * 32'(height_e);

	// Decode one byte
	always_comb begin
		phase_d    = phase_e;
		hdr_pos_d  = hdr_pos_e;
		id_left_d  = id_left_e;
		width_d    = width_e;
		height_d   = height_e;
		pix_left_d = pix_left_e;
		is_run_d   = is_run_e;
		pkt_left_d = pkt_left_e;
		byte_idx_d = byte_idx_e;
		asm_d      = asm_e;
		rep        = 8'd1;
		clamp      = 1'b0;
		last       = 1'b0;
		emit       = 1'b0;
		unique case (phase_e)
			PH_HEADER: begin
				case (hdr_pos_e)
					POS_ID_LEN: id_left_d       = b;
					POS_W_LO:   width_d[7:0]    = b;
					POS_W_HI:   width_d[15:8]   = b;
					POS_H_LO:   height_d[7:0]   = b;
					POS_H_HI:   height_d[15:8]  = b;
					default:    ;
				endcase
				hdr_pos_d = hdr_pos_e + HDR_POS_W'(1);
				if (hdr_pos_e == HDR_LAST) begin
					hdr_pos_d  = '0;
					pix_left_d = area;
					if (id_left_e != 8'd0) begin
						phase_d = PH_ID;
					end else if (width_e == 16'd0 || height_e == 16'd0) begin
						phase_d = PH_DONE;
					end else begin
						phase_d = PH_PKT;
					end
				end
			end
			PH_ID: begin
				id_left_d = id_left_e - 8'd1;
				if (id_left_d == 8'd0) begin
					phase_d = (pix_left_e == 32'd0) ? PH_DONE : PH_PKT;
				end
			end
			PH_PKT: begin
				is_run_d   = b[7];
				pkt_left_d = {1'b0, b[6:0]} + 8'd1;
				byte_idx_d = '0;
				asm_d      = '0;
				phase_d    = PH_PIX;
			end
			PH_PIX: begin
				if (byte_idx_e != LAST_BYTE) begin
					case (byte_idx_e)
						2'd0:    asm_d[7:0]   = b;
						2'd1:    asm_d[15:8]  = b;
						default: asm_d[23:16] = b;
					endcase
					byte_idx_d = byte_idx_e + 2'd1;
				end else begin
					emit       = 1'b1;
					byte_idx_d = '0;
					asm_d      = '0;
					if (is_run_e) begin
						clamp      = {24'd0, pkt_left_e} > pix_left_e;
						rep        = clamp ? pix_left_e[7:0] : pkt_left_e;
						pkt_left_d = '0;
					end else begin
						rep        = 8'd1;
						pkt_left_d = pkt_left_e - 8'd1;
					end
					pix_left_d = pix_left_e - {24'd0, rep};
					last       = (pix_left_d == 32'd0);
					if (!is_run_e) begin
						clamp = last && (pkt_left_d != 8'd0);
					end
					if (last || pkt_left_d == 8'd0) begin
						phase_d = last ? PH_DONE : PH_PKT;
					end
				end
			end
			default: ;
		endcase
	end

	// Advance the state on each consumed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_pos_q  <= '0;
			id_left_q  <= '0;
			width_q    <= '0;
			height_q   <= '0;
			pix_left_q <= '0;
			is_run_q   <= 1'b0;
			pkt_left_q <= '0;
			byte_idx_q <= '0;
			asm_q      <= '0;
		end else if (step_en) begin
			phase_q    <= phase_d;
			hdr_pos_q  <= hdr_pos_d;
			id_left_q  <= id_left_d;
			width_q    <= width_d;
			height_q   <= height_d;
			pix_left_q <= pix_left_d;
			is_run_q   <= is_run_d;
			pkt_left_q <= pkt_left_d;
			byte_idx_q <= byte_idx_d;
			asm_q      <= asm_d;
		end
	end

	assign res_valid          = emit;
	assign res.pixel_word     = {b, asm_e};
	assign res.repeat_count   = rep;
	assign res.image_width    = width_e;
	assign res.image_height   = height_e;
	assign res.last_of_image  = last;
	assign res.packet_clamped = clamp;

`ifndef SYNTHESIS
	a_pix_has_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PIX |-> pix_left_q != 32'd0)
		else $error("pixel phase with no pixels left");

	a_hdr_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_pos_q <= HDR_LAST)
		else $error("header position past end of header");

	a_rep_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res_valid |-> rep != 8'd0)
		else $error("result with zero repeat count");

	a_clamp_ends: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res_valid && clamp |-> last)
		else $error("clamped packet did not end the image");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res_valid && last |=> phase_q == PH_DONE)
		else $error("decoder not done after last pixel");
`endif

endmodule

FILE: src/tgarle_out_stage.sv
`timescale 1ns / 1ps

module tgarle_out_stage
	import tgarle_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  tgarle_result_t res,
	output logic           up_ready,
	output logic           out_valid,
	input  logic           out_stall,
	output tgarle_result_t out_res
);

	logic           valid_q;
	tgarle_result_t res_q;

	assign up_ready = !valid_q || !out_stall;

	// Hold the result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

FILE: src/tga_rle_pixel_decoder_core.sv
`timescale 1ns / 1ps

// Decodes a run-length-coded 32-bit TGA file fed one byte per beat. The
// 18-byte header and the id field give no results; each raw pixel gives one
// result with repeat count 1, and each run gives one result carrying its
// repeat count (not expanded). A packet that passes the end of the image is
// cut and flagged, and bytes after the image are dropped until the next
// start_of_file mark, which restarts the decoder from any state. The block
// accepts one beat per cycle unless out_stall holds the result register;
// results pass from input register to result register. The pace is set by
// the single decode step between the input register and the result
// register, which folds the whole byte into the decoder state at once.
module tga_rle_pixel_decoder_core
	import tgarle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  file_byte,
	input  logic        start_of_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] pixel_word,
	output logic [7:0]  repeat_count,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic        last_of_image,
	output logic        packet_clamped
);

	logic           beat_valid;
	tgarle_beat_t   beat;
	logic           down_ready;
	logic           step_en;
	logic           res_valid;
	tgarle_result_t res;
	tgarle_result_t out_res;

	assign step_en = beat_valid && down_ready;

	tgarle_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.file_byte     (file_byte),
		.start_of_file (start_of_file),
		.down_ready    (down_ready),
		.beat_valid    (beat_valid),
		.beat          (beat)
	);

	tgarle_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.beat      (beat),
		.res_valid (res_valid),
		.res       (res)
	);

	tgarle_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step_en && res_valid),
		.res       (res),
		.up_ready  (down_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign pixel_word     = out_res.pixel_word;
	assign repeat_count   = out_res.repeat_count;
	assign image_width    = out_res.image_width;
	assign image_height   = out_res.image_height;
	assign last_of_image  = out_res.last_of_image;
	assign packet_clamped = out_res.packet_clamped;

endmodule
